[hw/rtl/scr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the size class region allocator.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int ADDR_W      = 19;
  localparam int SIZE_W      = 17;
  localparam int REG_IDX_W   = 3;
  localparam int CLASS_REGS  = 7;
  localparam int LINK_IDX_W  = 15;

  localparam int DEF_NUM_REGIONS = 8;
  localparam int DEF_OFFSET_BITS = 16;
  localparam int DEF_GRAIN_SHIFT = 4;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_QUERY,
    K_ZERO,
    K_FALLBACK,
    K_IGNORE
  } kind_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr_out;
    logic [SIZE_W-1:0] usable_bytes;
  } rsp_t;

  // Classified work item handed from the front to the back.
  typedef struct packed {
    kind_e             kind;
    logic [2:0]        region;
    logic [ADDR_W-1:0] addr;
  } item_t;

  // Class size per region; entry 0 is always zero.
  typedef logic [7:0][SIZE_W-1:0] class_arr_t;

endpackage

[hw/rtl/scr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_front
// Classifies a request: picks the region and the kind of work to do.
// ----------------------------------------------------------------------------
module scr_front #(
  parameter int NUM_REGIONS = scr_pkg::DEF_NUM_REGIONS,
  parameter int OFFSET_BITS = scr_pkg::DEF_OFFSET_BITS
) (
  input  scr_pkg::req_t      req_i,
  input  scr_pkg::class_arr_t class_i,
  output scr_pkg::item_t     item_o
);
  import scr_pkg::*;

  logic [ADDR_W-1:0] addr_region;
  logic              addr_in_rgn;
  logic [2:0]        fit_region;
  logic              fit_found;

  assign addr_region = req_i.addr >> OFFSET_BITS;
  assign addr_in_rgn = (addr_region >= ADDR_W'(1)) &&
                       (addr_region < ADDR_W'(NUM_REGIONS));

  // First region in ascending order whose class covers the request.
  always_comb begin
    fit_region = '0;
    fit_found  = 1'b0;
    for (int r = NUM_REGIONS - 1; r >= 1; r--) begin
      if (class_i[r] >= req_i.req_size) begin
        fit_region = 3'(r);
        fit_found  = 1'b1;
      end
    end
  end

  always_comb begin
    item_o.addr   = req_i.addr;
    item_o.region = '0;
    item_o.kind   = K_IGNORE;
    unique case (req_i.opcode)
      OP_ALLOC: begin
        if (req_i.req_size == '0) begin
          item_o.kind = K_ZERO;
        end else if (fit_found) begin
          item_o.kind   = K_ALLOC;
          item_o.region = fit_region;
        end else begin
          item_o.kind = K_FALLBACK;
        end
      end
      OP_FREE: begin
        if (req_i.addr == '0) begin
          item_o.kind = K_IGNORE;
        end else if (addr_in_rgn) begin
          item_o.kind   = K_FREE;
          item_o.region = addr_region[2:0];
        end else begin
          item_o.kind = K_FALLBACK;
        end
      end
      OP_QUERY: begin
        item_o.kind   = K_QUERY;
        item_o.region = addr_in_rgn ? addr_region[2:0] : 3'd0;
      end
      default: item_o.kind = K_IGNORE;
    endcase
  end

endmodule

[hw/rtl/scr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module scr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output scr_pkg::item_t item_o
);
  import scr_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= item_i;
  end

endmodule

[hw/rtl/scr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_back
// Executes classified items: free list pops and pushes, bump allocation.
// ----------------------------------------------------------------------------
module scr_back #(
  parameter int NUM_REGIONS = scr_pkg::DEF_NUM_REGIONS,
  parameter int OFFSET_BITS = scr_pkg::DEF_OFFSET_BITS,
  parameter int GRAIN_SHIFT = scr_pkg::DEF_GRAIN_SHIFT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scr_pkg::class_arr_t class_i,
  input  logic                empty_i,
  input  scr_pkg::item_t      item_i,
  output logic                pop_o,
  output logic                done_o,
  output scr_pkg::rsp_t       rsp_o
);
  import scr_pkg::*;

  localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int END_W = (OFFSET_BITS + 4 > ADDR_W + 1) ? OFFSET_BITS + 4 : ADDR_W + 1;
  localparam int LINK_DEPTH = 1 << LINK_IDX_W;

  typedef enum logic [0:0] {S_IDLE, S_POP} state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] head_q [NUM_REGIONS];
  logic [ADDR_W-1:0] tail_q [NUM_REGIONS];
  logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
  logic [ADDR_W-1:0] link_rd_q;
  logic [RW-1:0]     rgn_q;
  logic [ADDR_W-1:0] pop_addr_q;
  logic              done_q;
  rsp_t              rsp_q;

  logic [RW-1:0]     rgn;
  logic [ADDR_W-1:0] head, tail;
  logic [END_W-1:0]  bump_next, rgn_end;
  logic              done_d;
  rsp_t              rsp_d;

  assign pop_o  = (state_q == S_IDLE) && !empty_i;
  assign rgn    = item_i.region[RW-1:0];
  assign head   = head_q[rgn];
  assign tail   = tail_q[rgn];
  assign bump_next = END_W'(tail) + END_W'(class_i[item_i.region]);
  assign rgn_end   = END_W'(item_i.region + 4'd1) << OFFSET_BITS;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  function automatic logic [LINK_IDX_W-1:0] link_idx(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] s;
    s = a >> GRAIN_SHIFT;
    return s[LINK_IDX_W-1:0];
  endfunction

  // Result of an item that completes in the cycle it is taken.
  always_comb begin
    rsp_d  = '{status: ST_OK, addr_out: '0, usable_bytes: '0};
    done_d = 1'b1;
    case (item_i.kind)
      K_ZERO:     rsp_d.status = ST_ZERO;
      K_FALLBACK: rsp_d.status = ST_FALLBACK;
      K_QUERY:    rsp_d.usable_bytes = class_i[item_i.region];
      K_FREE:     rsp_d.status = ST_OK;
      K_ALLOC: begin
        if (head == '0) begin
          rsp_d.status = ST_FALLBACK;
        end else if (head == tail) begin
          rsp_d.addr_out = head;
        end else begin
          // Next head comes from the registered link store read, in the pop state.
          done_d = 1'b0;
        end
      end
      default: rsp_d.status = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      rsp_q      <= '0;
      rgn_q      <= '0;
      pop_addr_q <= '0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        head_q[r] <= ADDR_W'(longint'(r) << OFFSET_BITS);
        tail_q[r] <= ADDR_W'(longint'(r) << OFFSET_BITS);
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= pop_o && done_d;
          if (pop_o) begin
            rsp_q <= rsp_d;
            if (item_i.kind == K_FREE) begin
              head_q[rgn] <= item_i.addr;
            end else if (item_i.kind == K_ALLOC && head != '0) begin
              if (head == tail) begin
                if (bump_next >= rgn_end) begin
                  tail_q[rgn] <= '0;
                  head_q[rgn] <= '0;
                end else begin
                  tail_q[rgn] <= bump_next[ADDR_W-1:0];
                  head_q[rgn] <= bump_next[ADDR_W-1:0];
                end
              end else begin
                state_q    <= S_POP;
                rgn_q      <= rgn;
                pop_addr_q <= head;
              end
            end
          end
        end
        S_POP: begin
          head_q[rgn_q]  <= link_rd_q;
          rsp_q.addr_out <= pop_addr_q;
          done_q         <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.kind == K_FREE) link_mem[link_idx(item_i.addr)] <= head;
  end

  always_ff @(posedge clk_i) begin
    link_rd_q <= link_mem[link_idx(head)];
  end

  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> done_q)
    else $error("free list pop did not complete");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> !done_q)
    else $error("result issued while pop pending");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> state_q == S_IDLE)
    else $error("pop state held too long");

endmodule

[hw/rtl/size_class_region_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_region_allocator
// Segregated-fit allocator with one block size per address region.
// ----------------------------------------------------------------------------
// Usage:
//   A request (allocate, free or usable-size query) is taken at a clock edge
//   where start is high and busy is low. Exactly one result follows on rsp_o,
//   marked by a one-cycle done_o strobe; the receiver cannot stall it.
//   A request is queued, then executed by the back end, which registers its
//   result; an allocate that pops a free list also passes the pop state,
//   as the next head comes from the link memory by a registered read. busy
//   is low again in the strobe cycle, so the next request can be taken then.
//   Class sizes are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; index i sets the class of region i+1.
//   Reset restores the default class sizes and points every region's head
//   and tail at its base address. The link memory needs no clearing: only
//   entries written by a free are ever read.
// ----------------------------------------------------------------------------
module size_class_region_allocator #(
  parameter int NUM_REGIONS = scr_pkg::DEF_NUM_REGIONS,
  parameter int OFFSET_BITS = scr_pkg::DEF_OFFSET_BITS,
  parameter int GRAIN_SHIFT = scr_pkg::DEF_GRAIN_SHIFT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  scr_pkg::req_t                   req_i,
  output logic                            done_o,
  output scr_pkg::rsp_t                   rsp_o,
  input  logic                            cfg_we_i,
  input  logic [scr_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scr_pkg::SIZE_W-1:0]      cfg_wdata_i
);
  import scr_pkg::*;

  class_arr_t class_q;
  logic       pending_q;
  logic       accept;
  item_t      front_item, queue_item;
  logic       q_full, q_empty, q_pop;

  assign busy   = pending_q && !done_o;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 8; r++) class_q[r] <= (r == 0) ? '0 : SIZE_W'(8 << r);
      pending_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i < REG_IDX_W'(CLASS_REGS)) begin
        class_q[cfg_idx_i + 3'd1] <= cfg_wdata_i;
      end
      if (accept) pending_q <= 1'b1;
      else if (done_o) pending_q <= 1'b0;
    end
  end

  scr_front #(
    .NUM_REGIONS(NUM_REGIONS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .req_i  (req_i),
    .class_i(class_q),
    .item_o (front_item)
  );

  scr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .item_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .item_o (queue_item)
  );

  scr_back #(
    .NUM_REGIONS(NUM_REGIONS),
    .OFFSET_BITS(OFFSET_BITS),
    .GRAIN_SHIFT(GRAIN_SHIFT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .class_i(class_q),
    .empty_i(q_empty),
    .item_i (queue_item),
    .pop_o  (q_pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after transaction accepted");
  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pending_q)
    else $error("result without pending transaction");
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !q_full)
    else $error("transaction accepted into full queue");

endmodule

[test/tb_size_class_region_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_region_allocator
// Self-checking testbench of the size class region allocator.
// ----------------------------------------------------------------------------
// A directed table covers the zero-size token, the class limits, fallback,
// region exhaustion, null and out-of-region frees, queries and the reserved
// opcode. Random allocate/free/query traffic follows over several class
// settings and sender idle rates. Every result is compared against its
// table entry or against an in-bench model of the free lists.
// ----------------------------------------------------------------------------
module tb_size_class_region_allocator;
  import scr_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1400;

  typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_PRED} row_kind_e;
  typedef struct {
    row_kind_e kind;
    req_t      rq;
    rsp_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;

  size_class_region_allocator u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow allocator state.
  logic [SIZE_W-1:0] class_sz [8];
  logic [ADDR_W-1:0] head_ptr [8];
  logic [ADDR_W-1:0] tail_ptr [8];
  logic [ADDR_W-1:0] next_link [0:32767];
  logic [ADDR_W-1:0] live_blocks [$];
  rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;

  function automatic rsp_t alloc_model(req_t q);
    rsp_t o;
    logic [2:0] reg_of;
    int found;
    logic [ADDR_W-1:0] p;
    logic [20:0] nt;
    o = '0;
    o.status = ST_IGNORED;
    reg_of = q.addr[ADDR_W-1:16];
    if (q.opcode == OP_ALLOC) begin
      if (q.req_size == 0) begin
        o.status = ST_ZERO;
      end else begin
        found = 0;
        for (int r = 7; r >= 1; r--) if (class_sz[r] >= q.req_size) found = r;
        if (found == 0 || head_ptr[found] == 0) begin
          o.status = ST_FALLBACK;
        end else begin
          p = head_ptr[found];
          if (p == tail_ptr[found]) begin
            nt = tail_ptr[found] + class_sz[found];
            tail_ptr[found] = (nt >= ((found + 1) << 16)) ? '0 : nt[ADDR_W-1:0];
            head_ptr[found] = tail_ptr[found];
          end else begin
            head_ptr[found] = next_link[p[ADDR_W-1:4]];
          end
          o.status = ST_OK;
          o.addr_out = p;
        end
      end
    end else if (q.opcode == OP_FREE) begin
      if (q.addr == 0) begin
        o.status = ST_IGNORED;
      end else if (reg_of != 0) begin
        next_link[q.addr[ADDR_W-1:4]] = head_ptr[reg_of];
        head_ptr[reg_of] = q.addr;
        o.status = ST_OK;
      end else begin
        o.status = ST_FALLBACK;
      end
    end else if (q.opcode == OP_QUERY) begin
      o.status = ST_OK;
      o.usable_bytes = (reg_of != 0) ? class_sz[reg_of] : '0;
    end
    return o;
  endfunction

  always begin
    @(posedge clk_i);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d", rsp_o.status);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.addr_out !== exp_rsp.addr_out) begin
          $error("addr_out: expected %h, got %h", exp_rsp.addr_out, rsp_o.addr_out);
          errors++;
        end
        if (rsp_o.usable_bytes !== exp_rsp.usable_bytes) begin
          $error("usable_bytes: expected %0d, got %0d", exp_rsp.usable_bytes,
                 rsp_o.usable_bytes);
          errors++;
        end
      end
    end
  end

  // Drives one transaction, waits for acceptance and records the outcome.
  task automatic issue(req_t q, int idle_pct, bit typed, rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i) start <= 1'b0;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= q;
    do @(posedge clk_i); while (busy);
    pred = alloc_model(q);
    if (q.opcode == OP_ALLOC && pred.status == ST_OK) live_blocks.push_back(pred.addr_out);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk_i) start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_class(int idx, logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[REG_IDX_W-1:0];
    cfg_wdata_i <= val;
    class_sz[idx + 1] = val;
  endtask

  task automatic end_writes();
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  function automatic row_t mk(row_kind_e k, logic [1:0] op, int sz, int a,
                              logic [1:0] st, int ao, int ub);
    row_t t;
    t.kind = k;
    t.rq = '{opcode: op, req_size: sz[SIZE_W-1:0], addr: a[ADDR_W-1:0]};
    t.want = '{status: st, addr_out: ao[ADDR_W-1:0], usable_bytes: ub[SIZE_W-1:0]};
    return t;
  endfunction

  initial begin
    row_t tbl [$];
    req_t q;
    int idle_pct;
    int pick;
    int base;

    for (int r = 0; r < 8; r++) begin
      class_sz[r] = (r == 0) ? '0 : SIZE_W'(8 << r);
      head_ptr[r] = ADDR_W'(r << 16);
      tail_ptr[r] = ADDR_W'(r << 16);
    end
    foreach (next_link[i]) next_link[i] = '0;

    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 0, 0, ST_ZERO, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 1, 0, ST_OK, 'h10000, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 16, 0, ST_OK, 'h10010, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 17, 0, ST_OK, 'h20000, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 1024, 0, ST_OK, 'h70000, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 1025, 0, ST_FALLBACK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 65536, 0, ST_FALLBACK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_FREE, 0, 0, ST_IGNORED, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_FREE, 0, 'h0FFF0, ST_FALLBACK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_FREE, 0, 'h10000, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_ALLOC, 16, 0, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_QUERY, 0, 'h10000, ST_OK, 0, 16));
    tbl.push_back(mk(ROW_TYPED, OP_QUERY, 0, 'h7FFFF, ST_OK, 0, 1024));
    tbl.push_back(mk(ROW_TYPED, OP_QUERY, 0, 0, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_QUERY, 131071, 'h0FFFF, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_RSVD, 131071, 'h7FFFF, ST_IGNORED, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_FREE, 0, 'h20005, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_ALLOC, 32, 0, ST_OK, 0, 0));
    // Class 1 grows to a whole region: the next bump runs past the end.
    tbl.push_back(mk(ROW_CFG, OP_ALLOC, 65536, 0, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_ALLOC, 1, 0, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 1, 0, ST_FALLBACK, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_FREE, 0, 'h10020, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_PRED, OP_ALLOC, 65536, 0, ST_OK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_ALLOC, 65536, 0, ST_FALLBACK, 0, 0));
    tbl.push_back(mk(ROW_TYPED, OP_QUERY, 0, 'h1FFFF, ST_OK, 0, 65536));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG) begin
        drain();
        write_class(0, tbl[i].rq.req_size);
        end_writes();
      end else begin
        issue(tbl[i].rq, 0, tbl[i].kind == ROW_TYPED, tbl[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      // Class settings: all minimum, all maximum, random ascending, large.
      base = 16;
      for (int r = 0; r < CLASS_REGS; r++) begin
        case (ph)
          0: write_class(r, SIZE_W'(16));
          1: write_class(r, SIZE_W'(65536));
          2: begin
            base = base + 16 * $urandom_range(0, 400);
            if (base > 65536) base = 65536;
            write_class(r, SIZE_W'(base));
          end
          default: write_class(r, SIZE_W'(4096 << (r % 5)));
        endcase
      end
      end_writes();
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 24 : 53;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        q = '0;
        q.req_size = SIZE_W'($urandom);
        q.addr = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 42) begin
          q.opcode = OP_ALLOC;
          if ($urandom_range(9) < 8) q.req_size = SIZE_W'($urandom_range(1, 1100));
          else q.req_size = SIZE_W'($urandom_range(0, 65536));
        end else if (pick < 77) begin
          q.opcode = OP_FREE;
          if (live_blocks.size() != 0 && $urandom_range(9) < 9) begin
            pick = $urandom_range(live_blocks.size() - 1);
            q.addr = live_blocks[pick];
            live_blocks.delete(pick);
          end
        end else if (pick < 95) begin
          q.opcode = OP_QUERY;
        end else if (pick < 97) begin
          q.opcode = OP_FREE;
          q.addr = '0;
        end else begin
          q.opcode = OP_RSVD;
        end
        issue(q, idle_pct, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scr_pkg.sv
hw/rtl/scr_front.sv
hw/rtl/scr_fifo.sv
hw/rtl/scr_back.sv
hw/rtl/size_class_region_allocator.sv
test/tb_size_class_region_allocator.sv
